### rtl/mgp_pkg.sv
`default_nettype none
package mgp_pkg;
  localparam int MAX_NODES = 64;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = IDX_W + 1;
  localparam int COORD_W   = 20;
  localparam int COST_W    = 30;
  localparam int RSUM_W    = COST_W + 1;
  localparam int DIST_W    = COORD_W + 1;
  localparam int STEP_W    = 52;
  localparam int TOTAL_W   = 58;
  localparam int PAR_W     = 7;
  localparam int PT_W      = 2 * COORD_W + 2 * COST_W;
  localparam int BEST_W    = STEP_W + PAR_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic emit;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic issue_last;
    logic pipe_empty;
    logic last_step;
  } status_t;
endpackage
`default_nettype wire

### rtl/mgp_ram.sv
`default_nettype none
module mgp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/mgp_ctrl.sv
`default_nettype none
module mgp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             last_point,
  input  wire mgp_pkg::status_t status,
  output mgp_pkg::cmd_t         cmd,
  output logic                  busy
);
  import mgp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          if (last_point) state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (status.issue_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (status.pipe_empty) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (status.last_step) begin
          cmd.clear  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_SCAN;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### rtl/mgp_dp.sv
`default_nettype none
module mgp_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mgp_pkg::cmd_t                 cmd,
  output mgp_pkg::status_t                   status,
  input  wire logic [mgp_pkg::COORD_W-1:0]   coord_x,
  input  wire logic [mgp_pkg::COORD_W-1:0]   coord_y,
  input  wire logic [mgp_pkg::COST_W-1:0]    station_cost,
  input  wire logic [mgp_pkg::COST_W-1:0]    wire_rate,
  output logic                               result_valid,
  output logic [mgp_pkg::PAR_W-1:0]          node_index,
  output logic [mgp_pkg::PAR_W-1:0]          parent_index,
  output logic [mgp_pkg::STEP_W-1:0]         step_cost,
  output logic [mgp_pkg::TOTAL_W-1:0]        running_total,
  output logic                               last_result
);
  import mgp_pkg::*;

  logic [CNT_W-1:0]     point_count;
  logic [CNT_W-1:0]     step_count;
  logic [CNT_W-1:0]     idx;
  logic [MAX_NODES-1:0] joined;
  logic [TOTAL_W-1:0]   total;
  logic                 upd_en;

  // Selected node of the previous step, the one the current pass relaxes against.
  logic [COORD_W-1:0] sel_x, sel_y;
  logic [COST_W-1:0]  sel_rate;
  logic [PAR_W-1:0]   sel_par;

  // Running minimum of the current pass.
  logic               found;
  logic [STEP_W-1:0]  min_cost;
  logic [PAR_W-1:0]   min_par;
  logic [IDX_W-1:0]   min_idx;
  logic [COORD_W-1:0] min_x, min_y;
  logic [COST_W-1:0]  min_rate;

  logic              load_we;
  logic [PT_W-1:0]   pt_q;
  logic [BEST_W-1:0] best_q;
  logic              best_we;
  logic [IDX_W-1:0]  best_waddr;
  logic [BEST_W-1:0] best_wdata;

  assign load_we = cmd.load && (point_count < CNT_W'(MAX_NODES));

  mgp_ram #(.WIDTH(PT_W), .DEPTH(MAX_NODES)) u_pt_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (point_count[IDX_W-1:0]),
    .wdata ({coord_x, coord_y, station_cost, wire_rate}),
    .raddr (idx[IDX_W-1:0]),
    .rdata (pt_q)
  );

  mgp_ram #(.WIDTH(BEST_W), .DEPTH(MAX_NODES)) u_best_ram (
    .clk   (clk),
    .we    (best_we),
    .waddr (best_waddr),
    .wdata (best_wdata),
    .raddr (idx[IDX_W-1:0]),
    .rdata (best_q)
  );

  // Pipeline stage registers.
  logic               v1, v2, v3;
  logic [IDX_W-1:0]   i1, i2, i3;
  logic [COORD_W-1:0] x2, y2, x3, y3;
  logic [COST_W-1:0]  r2, r3;
  logic [RSUM_W-1:0]  rs2;
  logic [DIST_W-1:0]  ds2;
  logic [STEP_W-1:0]  bc2, bc3, prod3;
  logic [PAR_W-1:0]   bp2, bp3;

  logic [COORD_W-1:0] p_x, p_y, dx, dy;
  logic [COST_W-1:0]  p_rate;

  assign p_x    = pt_q[PT_W-1 -: COORD_W];
  assign p_y    = pt_q[PT_W-1-COORD_W -: COORD_W];
  assign p_rate = pt_q[COST_W-1:0];
  assign dx     = (p_x > sel_x) ? (p_x - sel_x) : (sel_x - p_x);
  assign dy     = (p_y > sel_y) ? (p_y - sel_y) : (sel_y - p_y);

  logic              cand_ok, less, take;
  logic [STEP_W-1:0] new_cost;
  logic [PAR_W-1:0]  new_par;

  always_comb begin
    cand_ok  = v3 && !joined[i3];
    less     = upd_en && ((prod3 < bc3) || ((prod3 == bc3) && (sel_par < bp3)));
    new_cost = less ? prod3 : bc3;
    new_par  = less ? sel_par : bp3;
    take     = cand_ok && (!found || (new_cost < min_cost) ||
               ((new_cost == min_cost) && (new_par < min_par)));
    if (cmd.load) begin
      best_we    = load_we;
      best_waddr = point_count[IDX_W-1:0];
      best_wdata = {{(STEP_W-COST_W){1'b0}}, station_cost, {PAR_W{1'b0}}};
    end else begin
      best_we    = cand_ok && less;
      best_waddr = i3;
      best_wdata = {prod3, sel_par};
    end
  end

  always_comb begin
    status.issue_last = (idx == point_count - CNT_W'(1));
    status.pipe_empty = !v1 && !v2 && !v3;
    status.last_step  = (step_count == point_count - CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    i2    <= i1;
    x2    <= p_x;
    y2    <= p_y;
    r2    <= p_rate;
    rs2   <= {1'b0, p_rate} + {1'b0, sel_rate};
    ds2   <= {1'b0, dx} + {1'b0, dy};
    bc2   <= best_q[BEST_W-1 -: STEP_W];
    bp2   <= best_q[PAR_W-1:0];
    i3    <= i2;
    x3    <= x2;
    y3    <= y2;
    r3    <= r2;
    bc3   <= bc2;
    bp3   <= bp2;
    prod3 <= STEP_W'(rs2) * STEP_W'(ds2);
    i1    <= idx[IDX_W-1:0];
    if (take) begin
      min_cost <= new_cost;
      min_par  <= new_par;
      min_idx  <= i3;
      min_x    <= x3;
      min_y    <= y3;
      min_rate <= r3;
    end
    if (cmd.emit) begin
      sel_x         <= min_x;
      sel_y         <= min_y;
      sel_rate      <= min_rate;
      sel_par       <= PAR_W'(min_idx) + PAR_W'(1);
      node_index    <= PAR_W'(min_idx) + PAR_W'(1);
      parent_index  <= min_par;
      step_cost     <= min_cost;
      running_total <= total + TOTAL_W'(min_cost);
      last_result   <= status.last_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count  <= '0;
      step_count   <= '0;
      idx          <= '0;
      joined       <= '0;
      total        <= '0;
      upd_en       <= 1'b0;
      found        <= 1'b0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      v1           <= cmd.issue;
      v2           <= v1;
      v3           <= v2;
      result_valid <= cmd.emit;
      if (take) found <= 1'b1;
      if (cmd.issue) idx <= idx + CNT_W'(1);
      if (cmd.load) begin
        idx    <= '0;
        upd_en <= 1'b0;
        found  <= 1'b0;
        if (load_we) point_count <= point_count + CNT_W'(1);
      end
      if (cmd.emit) begin
        joined[min_idx] <= 1'b1;
        total           <= total + TOTAL_W'(min_cost);
        step_count      <= step_count + CNT_W'(1);
        upd_en          <= 1'b1;
        found           <= 1'b0;
        idx             <= '0;
      end
      if (cmd.clear) begin
        point_count <= '0;
        step_count  <= '0;
        joined      <= '0;
        total       <= '0;
      end
    end
  end
endmodule
`default_nettype wire

### rtl/manhattan_grid_prim_mst.sv
// Loading: one point per cycle; busy stays low while points load.
// Compute: each of the N tree steps takes one pass over the N nodes through a
// four-stage read, distance, multiply and compare pipeline.
// The block gives one result per step.
// Reset (rst, synchronous) empties the point set; results cannot be stalled.
`default_nettype none
module manhattan_grid_prim_mst (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [mgp_pkg::COORD_W-1:0]   coord_x,
  input  wire logic [mgp_pkg::COORD_W-1:0]   coord_y,
  input  wire logic [mgp_pkg::COST_W-1:0]    station_cost,
  input  wire logic [mgp_pkg::COST_W-1:0]    wire_rate,
  input  wire logic                          last_point,
  output logic                               result_valid,
  output logic [mgp_pkg::PAR_W-1:0]          node_index,
  output logic [mgp_pkg::PAR_W-1:0]          parent_index,
  output logic [mgp_pkg::STEP_W-1:0]         step_cost,
  output logic [mgp_pkg::TOTAL_W-1:0]        running_total,
  output logic                               last_result
);
  import mgp_pkg::*;

  // The controller sequences load, scan passes, pipeline drain and the emit
  // of each selected node; the datapath holds the stores and the arithmetic.
  cmd_t    cmd;
  status_t status;

  mgp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .last_point (last_point),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy)
  );

  // Each pass relaxes the stored best keys against the node chosen in the
  // previous step and, at the same time, tracks the lowest unjoined key,
  // which becomes the next node of the tree.
  mgp_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .coord_x       (coord_x),
    .coord_y       (coord_y),
    .station_cost  (station_cost),
    .wire_rate     (wire_rate),
    .result_valid  (result_valid),
    .node_index    (node_index),
    .parent_index  (parent_index),
    .step_cost     (step_cost),
    .running_total (running_total),
    .last_result   (last_result)
  );

`ifndef SYNTH
  a_result_in_compute: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy)) else $error("result outside compute");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_result) |=> !result_valid) else $error("result after last");
  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !last_point) |=> !busy) else $error("busy after plain load");
  a_node_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (node_index != '0)) else $error("zero node index");
`endif
endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import mgp_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  // One input point as presented on the command ports.
  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COST_W-1:0]  station;
    logic [COST_W-1:0]  rate;
    logic               last;
  } point_t;

  // One tree step as the block reports it.
  typedef struct {
    logic [PAR_W-1:0]   node;
    logic [PAR_W-1:0]   parent;
    logic [STEP_W-1:0]  cost;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } tree_step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [COORD_W-1:0] coord_x = '0;
  logic [COORD_W-1:0] coord_y = '0;
  logic [COST_W-1:0]  station_cost = '0;
  logic [COST_W-1:0]  wire_rate = '0;
  logic               last_point = 1'b0;
  logic               busy;
  logic               result_valid;
  logic [PAR_W-1:0]   node_index;
  logic [PAR_W-1:0]   parent_index;
  logic [STEP_W-1:0]  step_cost;
  logic [TOTAL_W-1:0] running_total;
  logic               last_result;

  manhattan_grid_prim_mst u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .coord_x(coord_x), .coord_y(coord_y), .station_cost(station_cost),
    .wire_rate(wire_rate), .last_point(last_point),
    .result_valid(result_valid), .node_index(node_index),
    .parent_index(parent_index), .step_cost(step_cost),
    .running_total(running_total), .last_result(last_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The predictor keeps its own copy of the point set.
  point_t     point_set[MAX_NODES];
  int         set_size = 0;
  tree_step_t tree_queue[$];
  int         error_count = 0;
  int         points_sent = 0;
  int         steps_seen = 0;
  int         sets_done = 0;
  int         idle_cycles = 0;

  function automatic logic [STEP_W-1:0] wire_price(int a, int b);
    logic [63:0] rsum;
    logic [63:0] span;
    logic [63:0] dx;
    logic [63:0] dy;
    rsum = 64'(point_set[a].rate) + 64'(point_set[b].rate);
    dx = (point_set[a].x > point_set[b].x) ? 64'(point_set[a].x - point_set[b].x)
                                           : 64'(point_set[b].x - point_set[a].x);
    dy = (point_set[a].y > point_set[b].y) ? 64'(point_set[a].y - point_set[b].y)
                                           : 64'(point_set[b].y - point_set[a].y);
    span = dx + dy;
    return STEP_W'(rsum * span);
  endfunction

  // Stores one point and, on the closing point, queues the whole tree in
  // selection order. Keys compare cost first, then parent, then node index.
  task automatic predict_tree(input point_t p);
    logic [STEP_W-1:0]  best_cost[MAX_NODES];
    logic [PAR_W-1:0]   best_par[MAX_NODES];
    bit                 joined[MAX_NODES];
    logic [TOTAL_W-1:0] acc;
    logic [STEP_W-1:0]  c;
    int                 sel;
    tree_step_t         s;
    if (set_size < MAX_NODES) begin
      point_set[set_size] = p;
      set_size++;
    end
    if (!p.last) return;
    for (int i = 0; i < set_size; i++) begin
      joined[i] = 1'b0;
      best_cost[i] = STEP_W'(point_set[i].station);
      best_par[i] = '0;
    end
    acc = '0;
    for (int k = 0; k < set_size; k++) begin
      sel = -1;
      for (int i = 0; i < set_size; i++) begin
        if (joined[i]) continue;
        if (sel < 0 || best_cost[i] < best_cost[sel] ||
            (best_cost[i] == best_cost[sel] && best_par[i] < best_par[sel]))
          sel = i;
      end
      joined[sel] = 1'b1;
      acc = acc + TOTAL_W'(best_cost[sel]);
      s.node = PAR_W'(sel + 1);
      s.parent = best_par[sel];
      s.cost = best_cost[sel];
      s.total = acc;
      s.last = (k + 1 == set_size);
      tree_queue.insert(tree_queue.size(), s);
      for (int i = 0; i < set_size; i++) begin
        if (joined[i]) continue;
        c = wire_price(i, sel);
        if (c < best_cost[i] || (c == best_cost[i] && PAR_W'(sel + 1) < best_par[i])) begin
          best_cost[i] = c;
          best_par[i] = PAR_W'(sel + 1);
        end
      end
    end
    set_size = 0;
  endtask

  // Results cannot be held off, so every strobed cycle is a transfer.
  always @(posedge clk) begin
    tree_step_t e;
    if (!rst && result_valid) begin
      steps_seen++;
      if (tree_queue.size() == 0) begin
        $error("unexpected result node_index=%0d", node_index);
        error_count++;
      end else begin
        e = tree_queue.pop_front();
        if (node_index !== e.node) begin
          $error("node_index expected %0d actual %0d", e.node, node_index);
          error_count++;
        end
        if (parent_index !== e.parent) begin
          $error("parent_index expected %0d actual %0d", e.parent, parent_index);
          error_count++;
        end
        if (step_cost !== e.cost) begin
          $error("step_cost expected %0d actual %0d", e.cost, step_cost);
          error_count++;
        end
        if (running_total !== e.total) begin
          $error("running_total expected %0d actual %0d", e.total, running_total);
          error_count++;
        end
        if (last_result !== e.last) begin
          $error("last_result expected %0d actual %0d", e.last, last_result);
          error_count++;
        end
        if (e.last) sets_done++;
      end
    end
  end

  // The watchdog counts cycles with no transfer on either side.
  always @(posedge clk) begin
    if ((start && !busy) || result_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout after %0d idle cycles", idle_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one, and long bursts with none.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Presents one point and holds it until the transfer edge. start is
  // only lowered when a gap follows, so it never toggles within one step.
  task automatic send_point(input point_t p);
    int g;
    g = gap_len();
    start <= 1'b1;
    coord_x <= p.x;
    coord_y <= p.y;
    station_cost <= p.station;
    wire_rate <= p.rate;
    last_point <= p.last;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_tree(p);
    points_sent++;
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic point_t rand_point(input bit last, input int mode);
    point_t p;
    p.x = COORD_W'($urandom);
    p.y = COORD_W'($urandom);
    p.station = COST_W'($urandom);
    p.rate = COST_W'($urandom);
    p.last = last;
    if (mode == 1) begin
      // Clustered small values force many ties in cost.
      p.x = COORD_W'($urandom_range(0, 3));
      p.y = COORD_W'($urandom_range(0, 3));
      p.station = COST_W'($urandom_range(0, 4));
      p.rate = COST_W'($urandom_range(0, 1));
    end else if (mode == 2) begin
      p.x = $urandom_range(0, 1) ? '1 : '0;
      p.y = $urandom_range(0, 1) ? '1 : '0;
      p.station = $urandom_range(0, 1) ? '1 : '0;
      p.rate = $urandom_range(0, 1) ? '1 : '0;
    end
    return p;
  endfunction

  // Directed rows: {x, y, station, rate, last}. Rows marked as a single
  // point have a result that follows from the station cost alone.
  point_t directed[] = '{
    '{20'd0, 20'd0, 30'd0, 30'd0, 1'b1},
    '{20'hFFFFF, 20'hFFFFF, 30'h3FFFFFFF, 30'h3FFFFFFF, 1'b1},
    '{20'd0, 20'd0, 30'h3FFFFFFF, 30'h3FFFFFFF, 1'b0},
    '{20'hFFFFF, 20'hFFFFF, 30'h3FFFFFFF, 30'h3FFFFFFF, 1'b1},
    '{20'd5, 20'd5, 30'd7, 30'd1, 1'b0},
    '{20'd5, 20'd5, 30'd7, 30'd1, 1'b0},
    '{20'd6, 20'd5, 30'd7, 30'd1, 1'b1},
    '{20'd1, 20'd2, 30'd100, 30'd3, 1'b0},
    '{20'd4, 20'd9, 30'd10, 30'd2, 1'b0},
    '{20'd0, 20'd0, 30'd50, 30'd0, 1'b0},
    '{20'd3, 20'd3, 30'd0, 30'd5, 1'b1}
  };

  initial begin
    int n;
    tree_step_t solo;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // First row: single point after reset, read straight off.
    send_point(directed[0]);
    solo = tree_queue[0];
    if (solo.node != 7'd1 || solo.parent != 7'd0 || solo.cost != '0 || !solo.last) begin
      $error("directed single point prediction off");
      error_count++;
    end
    for (int r = 1; r < directed.size(); r++) send_point(directed[r]);

    // A full set plus one overflow point, which must be dropped.
    for (int i = 0; i < MAX_NODES; i++) send_point(rand_point(1'b0, $urandom_range(0, 2)));
    send_point(rand_point(1'b1, 0));

    // Random sets, mostly small, with varied contents.
    while (points_sent < 265) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      for (int i = 0; i < n; i++)
        send_point(rand_point(i == n - 1, $urandom_range(0, 2)));
    end
    start <= 1'b0;

    while (tree_queue.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Sent %0d points in %0d sets, checked %0d tree steps",
             points_sent, sets_done, steps_seen);
    if (error_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire
